// ===== sv/gbs_pkg.sv =====
// shared constants and types for the streaming 3x3 gaussian blur
`timescale 1ns / 1ps

package gbs_pkg;

  // frame limits and pixel format
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_W      = 16;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // arithmetic widths
  localparam int SUM4_W = PIX_W + 2;
  localparam int PC_W   = COEF_W + PIX_W;
  localparam int PN_W   = COEF_W + SUM4_W;
  localparam int ACC_W  = PN_W + 2;
  localparam int FRAC_W = 16;

  // register reset values
  localparam logic [WID_W-1:0]  RST_FRAME_WIDTH  = WID_W'(640);
  localparam logic [HGT_W-1:0]  RST_FRAME_HEIGHT = HGT_W'(480);
  localparam logic [COEF_W-1:0] RST_COEF_CENTER  = COEF_W'(13380);
  localparam logic [COEF_W-1:0] RST_COEF_EDGE    = COEF_W'(8117);
  localparam logic [COEF_W-1:0] RST_COEF_CORNER  = COEF_W'(4922);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_COEF_CENTER  = 3'd2,
    CFG_COEF_EDGE    = 3'd3,
    CFG_COEF_CORNER  = 3'd4
  } cfg_idx_e;

  typedef logic [PIX_W-1:0] pix_t;

  // position and tagging of one item in the pipeline
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } tag_t;

endpackage

// ===== sv/gaussian_blur_3x3_stream.sv =====
// streaming 3x3 gaussian blur with two line buffers and a 3x3 window
//
// Pixels enter in raster order on the in_valid_i / in_ready_o channel, one
// transfer per pixel. For every interior pixel one filtered result leaves on
// the out_valid_o / out_ready_i channel with its row, column and a flag on
// the last interior pixel of the frame; border pixels give no result. The
// result for pixel (r-1, c-1) follows the transfer of input pixel (r, c).
// Throughput is one pixel per cycle while the receiver does not stall. The
// path from the input transfer to out_valid_o: the transfer edge loads the
// input register and the line buffer reads, then window shift, neighbor
// sums, three parallel multipliers, and the final add, rounding and
// saturation into the output register. The line buffers are single write,
// single read memories; the upper buffer write back trails the read by one stage.
// If the receiver stalls, the output register holds and empty stages in
// front of it keep filling, so in_ready_o drops only once every stage holds
// an item. Reset clears the pipeline, the window and the position counters
// and loads the default frame size and kernel; line buffer contents are
// left as they are; only values written in the frame reach a result.
// Configuration writes on cfg_we_i take effect at once and are meant for
// an idle block.
`timescale 1ns / 1ps

module gaussian_blur_3x3_stream
  import gbs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      pixel_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      pixel_out_o,
  output logic [ROW_W-1:0]      out_row_o,
  output logic [COL_W-1:0]      out_col_o,
  output logic                  frame_last_o
);

  // configuration registers
  logic [WID_W-1:0]  frame_width_q;
  logic [HGT_W-1:0]  frame_height_q;
  logic [COEF_W-1:0] coef_center_q, coef_edge_q, coef_corner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RST_FRAME_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
      coef_center_q  <= RST_COEF_CENTER;
      coef_edge_q    <= RST_COEF_EDGE;
      coef_corner_q  <= RST_COEF_CORNER;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[WID_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[HGT_W-1:0];
        CFG_COEF_CENTER:  coef_center_q  <= cfg_data_i[COEF_W-1:0];
        CFG_COEF_EDGE:    coef_edge_q    <= cfg_data_i[COEF_W-1:0];
        CFG_COEF_CORNER:  coef_corner_q  <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size: zero acts as one, oversize clamps
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;

  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = WID_W'(1);
    end else if (frame_width_q > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width_q;
    end
    if (frame_height_q == '0) begin
      h_eff = HGT_W'(1);
    end else if (frame_height_q > HGT_W'(MAX_HEIGHT)) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height_q;
    end
  end

  // pipeline valid bits and ready chain
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, out_vld_q;
  logic out_rdy, s4_rdy, s3_rdy, s2_rdy, s1_rdy;
  logic in_acc, s1_adv;

  assign out_rdy    = !out_vld_q || out_ready_i;
  assign s4_rdy     = !s4_vld_q || out_rdy;
  assign s3_rdy     = !s3_vld_q || s4_rdy;
  assign s2_rdy     = !s2_vld_q || s3_rdy;
  assign s1_rdy     = !s1_vld_q || s2_rdy;
  assign in_ready_o = s1_rdy;
  assign in_acc     = in_valid_i && s1_rdy;
  assign s1_adv     = s1_vld_q && s2_rdy;

  // position counters
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [WID_W-1:0] col_inc;
  logic [HGT_W-1:0] row_inc;
  logic             end_row, end_frame, emit;

  assign col_inc   = {{(WID_W-COL_W){1'b0}}, col_q} + WID_W'(1);
  assign row_inc   = {{(HGT_W-ROW_W){1'b0}}, row_q} + HGT_W'(1);
  assign end_row   = col_inc >= w_eff;
  assign end_frame = end_row && (row_inc >= h_eff);
  assign emit      = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2))
                  && ({{(WID_W-COL_W){1'b0}}, col_q} < w_eff)
                  && ({{(HGT_W-ROW_W){1'b0}}, row_q} < h_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (end_row) begin
        col_q <= '0;
        row_q <= end_frame ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_q <= col_inc[COL_W-1:0];
      end
    end
  end

  // line buffers: middle written on transfer, upper written as stage 1 leaves
  pix_t lb_upper_q  [MAX_WIDTH];
  pix_t lb_middle_q [MAX_WIDTH];
  pix_t up_rd_q, mid_rd_q, fwd_data_q;
  logic fwd_q;
  logic [COL_W-1:0] s1_addr_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mid_rd_q           <= lb_middle_q[col_q];
      lb_middle_q[col_q] <= pixel_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      lb_upper_q[s1_addr_q] <= mid_rd_q;
    end
    if (in_acc) begin
      up_rd_q <= lb_upper_q[col_q];
    end
  end

  // bypass for a read of the column being written back in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc) begin
      fwd_q <= s1_adv && (s1_addr_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_data_q <= mid_rd_q;
    end
  end

  // stage 1: item with its line buffer reads
  pix_t s1_pix_q;
  tag_t s1_tag_q;
  logic s1_emit_q;
  pix_t up_eff;

  assign up_eff = fwd_q ? fwd_data_q : up_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q      <= pixel_in_i;
      s1_addr_q     <= col_q;
      s1_emit_q     <= emit;
      s1_tag_q.row  <= row_q - ROW_W'(1);
      s1_tag_q.col  <= col_q - COL_W'(1);
      s1_tag_q.last <= end_frame;
    end
  end

  // window shift: every item shifts, only interior items go on
  pix_t win_q [9];
  tag_t s2_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (s1_adv) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3]   <= win_q[k*3+1];
        win_q[k*3+1] <= win_q[k*3+2];
      end
      win_q[2] <= up_eff;
      win_q[5] <= mid_rd_q;
      win_q[8] <= s1_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_q <= s1_vld_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_tag_q <= s1_tag_q;
    end
  end

  // stage 3: neighbor sums
  logic [SUM4_W-1:0] edges_q, corners_q;
  pix_t              center_q;
  tag_t              s3_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy && s2_vld_q) begin
      edges_q   <= SUM4_W'(win_q[1]) + SUM4_W'(win_q[3])
                 + SUM4_W'(win_q[5]) + SUM4_W'(win_q[7]);
      corners_q <= SUM4_W'(win_q[0]) + SUM4_W'(win_q[2])
                 + SUM4_W'(win_q[6]) + SUM4_W'(win_q[8]);
      center_q  <= win_q[4];
      s3_tag_q  <= s2_tag_q;
    end
  end

  // stage 4: weight products
  logic [PC_W-1:0] prod_c_q;
  logic [PN_W-1:0] prod_e_q, prod_k_q;
  tag_t            s4_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (s4_rdy) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_rdy && s3_vld_q) begin
      prod_c_q <= PC_W'(coef_center_q) * PC_W'(center_q);
      prod_e_q <= PN_W'(coef_edge_q) * PN_W'(edges_q);
      prod_k_q <= PN_W'(coef_corner_q) * PN_W'(corners_q);
      s4_tag_q <= s3_tag_q;
    end
  end

  // final sum, round half up and saturate
  logic [ACC_W-1:0]       acc;
  logic [ACC_W-FRAC_W-1:0] res;
  pix_t                   res_sat;

  assign acc     = ACC_W'(prod_c_q) + ACC_W'(prod_e_q) + ACC_W'(prod_k_q)
                 + ACC_W'(32768);
  assign res     = acc[ACC_W-1:FRAC_W];
  assign res_sat = (|res[ACC_W-FRAC_W-1:PIX_W]) ? '1 : res[PIX_W-1:0];

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && s4_vld_q) begin
      pixel_out_o  <= res_sat;
      out_row_o    <= s4_tag_q.row;
      out_col_o    <= s4_tag_q.col;
      frame_last_o <= s4_tag_q.last;
    end
  end

  assign out_valid_o = out_vld_q;

`ifndef SYNTHESIS
  // end of frame brings the counters back to the origin
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && end_frame |=> (row_q == '0) && (col_q == '0))
    else $error("position counters did not wrap at end of frame");

  // a product held behind a stalled output is not dropped
  a_s4_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_vld_q && !out_rdy |=> s4_vld_q)
    else $error("stage 4 item lost while output stalled");

  // a border pixel never starts the arithmetic stages
  a_border_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_rdy && s1_vld_q && !s1_emit_q |=> !s2_vld_q)
    else $error("border pixel entered the filter stages");
`endif

endmodule
